// ===== rtl/fpa_pkg.sv =====
// Package with opcodes, sizes and packing constants for the fixed-point ALU.
package fpa_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned FracBitsDefault = 8;
  localparam int unsigned InTdataW  = 72;  // op, operand_a, operand_b, 4 bits padding
  localparam int unsigned OutTdataW = 40;  // value_out, compare_true, divide_by_zero, padding

  typedef enum logic [3:0] {
    OpAdd     = 4'd0,
    OpSub     = 4'd1,
    OpMul     = 4'd2,
    OpDiv     = 4'd3,
    OpGt      = 4'd4,
    OpLt      = 4'd5,
    OpGe      = 4'd6,
    OpLe      = 4'd7,
    OpEq      = 4'd8,
    OpNe      = 4'd9,
    OpMin     = 4'd10,
    OpMax     = 4'd11,
    OpInc     = 4'd12,
    OpDec     = 4'd13,
    OpToInt   = 4'd14,
    OpFromInt = 4'd15
  } op_e;

endpackage

// ===== rtl/fixed_point_alu.sv =====
// Top level of the pipelined signed fixed-point ALU.
//
// One request enters on the s_axis channel: tdata carries op (bits 3:0),
// operand_a (35:4) and operand_b (67:36). One result leaves on m_axis for
// every request, in order: value_out (31:0), compare_true (32) and
// divide_by_zero (33).
// Every request, whatever its opcode, goes through the same pipeline of
// 32 + FRAC_BITS + 4 register stages. The divider resolves one quotient
// bit per stage and sets that depth; the multiply is split over two stages
// of 32x16 products. Throughput is one request per cycle unless the
// receiver stalls the output.
// The output register is the last pipeline stage. When the receiver holds
// m_axis_tready low with a result waiting, the whole pipeline freezes and
// s_axis_tready falls; nothing is lost or repeated. A free output slot lets
// the pipeline advance even while a result is being taken.
// Reset clears all valid bits; the block keeps no other state.
module fixed_point_alu import fpa_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [InTdataW-1:0]   s_axis_tdata,   // op, operand_a, operand_b, zero pad
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OutTdataW-1:0]  m_axis_tdata    // value_out, compare_true, divide_by_zero, pad
);

  typedef struct packed {
    logic [3:0]             op;
    logic signed [DataW-1:0] a;
    logic signed [DataW-1:0] b;
    logic [DataW-1:0]       simple;  // result of every op other than mul and div
    logic                   cmp;
    logic [2*DataW-1:0]     prod;
  } tag_t;

  localparam int unsigned TagW = $bits(tag_t);
  localparam int unsigned HalfW = DataW / 2;

  logic en;
  logic out_v_q;
  assign en = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  logic [3:0]              in_op;
  logic signed [DataW-1:0] in_a, in_b;
  assign in_op = s_axis_tdata[3:0];
  assign in_a  = s_axis_tdata[DataW+3:4];
  assign in_b  = s_axis_tdata[2*DataW+3:DataW+4];

  // Stage 1: simple results and comparisons.
  logic [DataW-1:0] simple_d;
  logic             cmp_d;
  logic [DataW-1:0] toint_v;
  logic signed [DataW-1:0] bias;
  assign bias    = in_a[DataW-1] ? DataW'((1 << FracBits) - 1) : '0;
  assign toint_v = DataW'((in_a + bias) >>> FracBits);

  always_comb begin
    simple_d = '0;
    cmp_d    = 1'b0;
    case (op_e'(in_op))
      OpAdd:     simple_d = DataW'(in_a + in_b);
      OpSub:     simple_d = DataW'(in_a - in_b);
      OpGt:      cmp_d = in_a > in_b;
      OpLt:      cmp_d = in_a < in_b;
      OpGe:      cmp_d = in_a >= in_b;
      OpLe:      cmp_d = in_a <= in_b;
      OpEq:      cmp_d = in_a == in_b;
      OpNe:      cmp_d = in_a != in_b;
      OpMin:     simple_d = (in_a < in_b) ? in_a : in_b;
      OpMax:     simple_d = (in_a > in_b) ? in_a : in_b;
      OpInc:     simple_d = DataW'(in_a + 1);
      OpDec:     simple_d = DataW'(in_a - 1);
      OpToInt:   simple_d = toint_v;
      OpFromInt: simple_d = in_a << FracBits;
      default:   simple_d = '0;
    endcase
  end

  tag_t t0;
  always_comb begin
    t0        = '0;
    t0.op     = in_op;
    t0.a      = in_a;
    t0.b      = in_b;
    t0.simple = simple_d;
    t0.cmp    = cmp_d;
  end

  logic             dv;
  tag_t             dt;
  logic [DataW-1:0] dq;

  fpa_div #(.FracBits(FracBits), .TagW(TagW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .tag_i   (t0),
    .a_i     (in_a),
    .b_i     (in_b),
    .valid_o (dv),
    .tag_o   (dt),
    .quot_o  (dq)
  );

  // Multiply in two stages of signed-by-half partial products.
  logic             m1_v_q, m2_v_q;
  tag_t             m1_t_q, m2_t_q;
  tag_t             m2_t_d;
  logic [DataW-1:0] m1_q_q, m2_q_q;
  logic signed [DataW+HalfW:0] plo_q, phi_q;
  logic signed [2*DataW-1:0]   prod_full;

  assign prod_full = ((2*DataW)'(phi_q) <<< HalfW) + (2*DataW)'(plo_q);

  always_comb begin
    m2_t_d      = m1_t_q;
    m2_t_d.prod = prod_full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q  <= 1'b0;
      m2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      m1_v_q  <= dv;
      m2_v_q  <= m1_v_q;
      out_v_q <= m2_v_q;
    end
  end

  logic [DataW-1:0] value_q;
  logic             cmp_q, dz_q;
  logic [DataW-1:0] value_d;
  logic             dz_d;
  logic signed [2*DataW-1:0] shifted_prod;
  assign shifted_prod = $signed(m2_t_q.prod) >>> FracBits;

  always_comb begin
    dz_d    = 1'b0;
    value_d = m2_t_q.simple;
    case (op_e'(m2_t_q.op))
      OpMul: value_d = shifted_prod[DataW-1:0];
      OpDiv: begin
        dz_d    = (m2_t_q.b == '0);
        value_d = dz_d ? '0 : m2_q_q;
      end
      default: value_d = m2_t_q.simple;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_t_q <= dt;
      m1_q_q <= dq;
      plo_q  <= dt.a * $signed({1'b0, dt.b[HalfW-1:0]});
      phi_q  <= dt.a * $signed(dt.b[DataW-1:HalfW]);
      m2_t_q <= m2_t_d;
      m2_q_q <= m1_q_q;
      value_q <= value_d;
      cmp_q   <= m2_t_q.cmp;
      dz_q    <= dz_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {{(OutTdataW-DataW-2){1'b0}}, dz_q, cmp_q, value_q};

endmodule

// ===== rtl/fpa_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with stall support.
module fpa_div import fpa_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDefault,
  parameter int unsigned TagW     = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [TagW-1:0]          tag_i,
  input  logic signed [DataW-1:0]  a_i,
  input  logic signed [DataW-1:0]  b_i,
  output logic                     valid_o,
  output logic [TagW-1:0]          tag_o,
  output logic [DataW-1:0]         quot_o
);

  // Dividend magnitude a * 2^FracBits needs DataW + FracBits bits.
  localparam int unsigned NW = DataW + FracBits;
  localparam int unsigned Steps = NW;

  logic [Steps:0]            v_q;
  logic [TagW-1:0]           tag_q [Steps+1];
  logic [NW-1:0]             num_q [Steps+1];
  logic [DataW:0]            rem_q [Steps+1];
  logic [DataW-1:0]          den_q [Steps+1];
  logic                      neg_q [Steps+1];

  logic [DataW-1:0] a_mag, b_mag;
  assign a_mag = a_i[DataW-1] ? DataW'(-a_i) : DataW'(a_i);
  assign b_mag = b_i[DataW-1] ? DataW'(-b_i) : DataW'(b_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[Steps-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0] <= tag_i;
      num_q[0] <= {a_mag, {FracBits{1'b0}}};
      rem_q[0] <= '0;
      den_q[0] <= b_mag;
      neg_q[0] <= a_i[DataW-1] ^ b_i[DataW-1];
    end
  end

  // Each stage shifts in one dividend bit and tries a subtraction.
  for (genvar s = 0; s < Steps; s++) begin : g_stage
    logic [DataW+1:0] trial;
    logic [DataW:0]   shifted;
    assign shifted = {rem_q[s][DataW-1:0], num_q[s][NW-1]};
    assign trial   = {1'b0, shifted} - {2'b00, den_q[s]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[s+1] <= tag_q[s];
        den_q[s+1] <= den_q[s];
        neg_q[s+1] <= neg_q[s];
        if (!trial[DataW+1]) begin
          rem_q[s+1] <= trial[DataW:0];
          num_q[s+1] <= {num_q[s][NW-2:0], 1'b1};
        end else begin
          rem_q[s+1] <= shifted;
          num_q[s+1] <= {num_q[s][NW-2:0], 1'b0};
        end
      end
    end
  end

  logic [DataW-1:0] q_mag;
  assign q_mag   = num_q[Steps][DataW-1:0];
  assign quot_o  = neg_q[Steps] ? DataW'(-q_mag) : q_mag;
  assign valid_o = v_q[Steps];
  assign tag_o   = tag_q[Steps];

endmodule

// ===== sim/fpa_checker.sv =====
// Checker that predicts every fixed-point ALU result and compares it with the block's output.
`timescale 1ns / 1ps
module fpa_checker import fpa_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  input  logic [InTdataW-1:0]  s_tdata_i,
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  input  logic [OutTdataW-1:0] m_tdata_i,
  output int                   errors_o,
  output int                   pending_o
);

  typedef struct packed {
    logic [31:0] value;
    logic        compare_true;
    logic        div_zero;
  } alu_result_t;

  alu_result_t expected_q[$];

  function automatic alu_result_t alu_compute(op_e op, logic signed [31:0] a,
                                              logic signed [31:0] b);
    alu_result_t r;
    logic signed [63:0] wide;
    r = '0;
    case (op)
      OpAdd: r.value = a + b;
      OpSub: r.value = a - b;
      OpMul: begin
        wide = 64'(a) * 64'(b);
        r.value = 32'(wide >>> FracBits);
      end
      OpDiv: begin
        if (b == 0) begin
          r.div_zero = 1'b1;
        end else begin
          wide = (64'(a) <<< FracBits) / 64'(b);
          r.value = wide[31:0];
        end
      end
      OpGt: r.compare_true = a > b;
      OpLt: r.compare_true = a < b;
      OpGe: r.compare_true = a >= b;
      OpLe: r.compare_true = a <= b;
      OpEq: r.compare_true = a == b;
      OpNe: r.compare_true = a != b;
      OpMin: r.value = (a < b) ? a : b;
      OpMax: r.value = (a > b) ? a : b;
      OpInc: r.value = a + 1;
      OpDec: r.value = a - 1;
      OpToInt: begin
        wide = 64'(a) / (64'sd1 <<< FracBits);
        r.value = wide[31:0];
      end
      default: r.value = a <<< FracBits;
    endcase
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    alu_result_t want, got;
    if (!rst_ni) begin
      errors_o <= 0;
    end else begin
      if (s_tvalid_i && s_tready_i)
        expected_q.push_back(alu_compute(op_e'(s_tdata_i[3:0]), s_tdata_i[35:4],
                                         s_tdata_i[67:36]));
      if (m_tvalid_i && m_tready_i) begin
        got.value = m_tdata_i[31:0];
        got.compare_true = m_tdata_i[32];
        got.div_zero = m_tdata_i[33];
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected, actual %h", $time, got);
          errors_o <= errors_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (got != want || m_tdata_i[39:34] != '0) begin
            $display("%0t: mismatch, expected value %h cmp %b dz %b, actual value %h cmp %b dz %b",
                     $time, want.value, want.compare_true, want.div_zero,
                     got.value, got.compare_true, got.div_zero);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

// ===== sim/tb.sv =====
// Top of the fixed-point ALU testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
  import fpa_pkg::*;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;
  int                   errors;
  int                   pending;
  int                   cycles;
  int                   send_idle;
  int                   recv_idle;

  fixed_point_alu dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  fpa_checker checker_i (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready), .s_tdata_i(s_axis_tdata),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready), .m_tdata_i(m_axis_tdata),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > 400000) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // The receiver stalls at the rate set for the current phase.
  always @(negedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= recv_idle);

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return $urandom_range(1) ? 32'hffff_ffff : 32'd1;
      4: return 32'($signed($urandom_range(4096)) - 2048);
      default: return $urandom;
    endcase
  endfunction

  task automatic send(op_e op, logic [31:0] a, logic [31:0] b);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, b, a, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    op_e op;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    send_idle = 10;
    recv_idle = 65;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Every operation on the range extremes, then divide by zero and wide results.
    for (int i = 0; i < 16; i++)
      send(op_e'(i), 32'h8000_0000, 32'h7fff_ffff);
    send(OpDiv, 32'h0000_1234, 32'd0);
    send(OpDiv, 32'h7fff_ffff, 32'd1);
    send(OpDiv, 32'h8000_0000, 32'hffff_ffff);
    send(OpMul, 32'h7fff_ffff, 32'h7fff_ffff);
    send(OpMul, 32'hffff_ffff, 32'd1);
    send(OpToInt, 32'hffff_ff01, 32'd0);
    send(OpEq, 32'd5, 32'd5);
    send(OpFromInt, 32'h7fff_ffff, 32'hffff_ffff);

    for (int i = 0; i < 900; i++) begin
      if (i == 300) begin
        send_idle = 65;
        recv_idle = 10;
      end else if (i == 600) begin
        send_idle = 0;
        recv_idle = 0;
      end
      op = op_e'($urandom_range(15));
      send(op, pick_operand(), ($urandom_range(9) == 0) ? 32'd0 : pick_operand());
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
